[design/ps2mct_pkg.sv]
`timescale 1ns / 1ps

package ps2mct_pkg;

   localparam int CFG_W    = 13;
   localparam int PIXEL_W  = 12;
   localparam int CELL_X_W = 9;
   localparam int CELL_Y_W = 8;
   localparam int BTN_W    = 3;
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 2;

   // Header byte fields.
   localparam int SYNC_BIT   = 3;
   localparam int X_SIGN_BIT = 4;
   localparam int Y_SIGN_BIT = 5;

   // Character cell is 8 pixels wide and 16 pixels high.
   localparam int CELL_W_SHIFT = 3;
   localparam int CELL_H_SHIFT = 4;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd1024;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd768;

   localparam logic [INDEX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
   localparam logic [INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

   // Position within a three byte packet.
   typedef enum logic [2:0] {
      POS_HEADER = 3'b001,
      POS_X_MOVE = 3'b010,
      POS_Y_MOVE = 3'b100
   } byte_pos_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]  pixel_x;
      logic [PIXEL_W-1:0]  pixel_y;
      logic [CELL_X_W-1:0] cell_x;
      logic [CELL_Y_W-1:0] cell_y;
      logic [BTN_W-1:0]    buttons;
   } result_type;

endpackage

[design/ps2_mouse_packet_cursor_tracker.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  data_ready, from_auxiliary, packet_byte
// rsp       out        rsp_valid / rsp_ready  pixel_x, pixel_y, cell_x, cell_y, buttons
// csr       in         csr_write_en           csr_index, csr_write_data
//
// One request is taken per clock while req_ready is high; a packet's third byte has its
// clamped result registered in the output register, or in the skid register if stalled.
// A two-entry output buffer (output register plus skid register) keeps requests
// flowing while a response is stalled; req_ready drops only while the skid is full.
// Synchronous reset returns the pointer to (512, 384) and waits for a header byte.
module ps2_mouse_packet_cursor_tracker #(
   parameter int COORD_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_data_ready,
   input  logic                                req_from_auxiliary,
   input  logic [ps2mct_pkg::BYTE_W-1:0]       req_packet_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ps2mct_pkg::PIXEL_W-1:0]      rsp_pixel_x,
   output logic [ps2mct_pkg::PIXEL_W-1:0]      rsp_pixel_y,
   output logic [ps2mct_pkg::CELL_X_W-1:0]     rsp_cell_x,
   output logic [ps2mct_pkg::CELL_Y_W-1:0]     rsp_cell_y,
   output logic [ps2mct_pkg::BTN_W-1:0]        rsp_buttons,
   input  logic                                csr_write_en,
   input  logic [ps2mct_pkg::INDEX_W-1:0]      csr_index,
   input  logic [ps2mct_pkg::CFG_W-1:0]        csr_write_data
);
   import ps2mct_pkg::*;

   localparam int SUM_W = COORD_BITS + 2;
   localparam int CMP_W = (COORD_BITS + 1 > CFG_W) ? COORD_BITS + 1 : CFG_W;
   localparam int OUT_W = (COORD_BITS > PIXEL_W) ? COORD_BITS : PIXEL_W;
   localparam logic [COORD_BITS-1:0] X_RESET = COORD_BITS'(512);
   localparam logic [COORD_BITS-1:0] Y_RESET = COORD_BITS'(384);

   logic [CFG_W-1:0]      width_ff, width_in;
   logic [CFG_W-1:0]      height_ff, height_in;
   byte_pos_type          pos_ff, pos_in;
   logic [BYTE_W-1:0]     header_ff, header_in;
   logic [BYTE_W-1:0]     xmove_ff, xmove_in;
   logic [COORD_BITS-1:0] ptr_x_ff, ptr_x_in;
   logic [COORD_BITS-1:0] ptr_y_ff, ptr_y_in;
   logic                  out_valid_ff, out_valid_in;
   result_type            out_ff, out_in;
   logic                  skid_valid_ff, skid_valid_in;
   result_type            skid_ff, skid_in;

   logic                  accept;
   logic                  take_byte;
   logic                  produce;
   logic                  stalled;
   logic [COORD_BITS-1:0] max_x, max_y;
   logic [COORD_BITS-1:0] new_x, new_y;
   logic [SUM_W-1:0]      sum_x, sum_y;
   logic [OUT_W-1:0]      ext_x, ext_y;
   result_type            result;

   // Largest coordinate for a screen size: zero acts as one, sizes beyond the
   // coordinate range saturate.
   function automatic logic [COORD_BITS-1:0] max_coord(input logic [CFG_W-1:0] size);
      logic [CMP_W-1:0] size_w;
      logic [CMP_W-1:0] cap;
      size_w = CMP_W'(size);
      cap    = CMP_W'(1) << COORD_BITS;
      if (size == '0) begin
         return '0;
      end else if (size_w >= cap) begin
         return '1;
      end
      return COORD_BITS'(size_w - CMP_W'(1));
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp(input logic [SUM_W-1:0] sum,
                                                   input logic [COORD_BITS-1:0] lim);
      if ($signed(sum) < 0) begin
         return '0;
      end else if ($signed(sum) > $signed({2'b00, lim})) begin
         return lim;
      end
      return sum[COORD_BITS-1:0];
   endfunction

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign take_byte = accept && req_data_ready && req_from_auxiliary;
   assign stalled   = out_valid_ff && !rsp_ready;

   assign max_x = max_coord(width_ff);
   assign max_y = max_coord(height_ff);

   // Nine bit deltas: the sign comes from the header, the low eight bits from the move byte.
   assign sum_x = {2'b00, ptr_x_ff}
                + {{(SUM_W - BYTE_W){header_ff[X_SIGN_BIT]}}, xmove_ff};
   assign sum_y = {2'b00, ptr_y_ff}
                - {{(SUM_W - BYTE_W){header_ff[Y_SIGN_BIT]}}, req_packet_byte};
   assign new_x = clamp(sum_x, max_x);
   assign new_y = clamp(sum_y, max_y);

   assign ext_x = OUT_W'(new_x);
   assign ext_y = OUT_W'(new_y);
   always_comb begin
      result.pixel_x = ext_x[PIXEL_W-1:0];
      result.pixel_y = ext_y[PIXEL_W-1:0];
      result.cell_x  = ext_x[CELL_X_W+CELL_W_SHIFT-1:CELL_W_SHIFT];
      result.cell_y  = ext_y[CELL_Y_W+CELL_H_SHIFT-1:CELL_H_SHIFT];
      result.buttons = header_ff[BTN_W-1:0];
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_SCREEN_WIDTH:  width_in  = csr_write_data;
            REG_SCREEN_HEIGHT: height_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      pos_in    = pos_ff;
      header_in = header_ff;
      xmove_in  = xmove_ff;
      ptr_x_in  = ptr_x_ff;
      ptr_y_in  = ptr_y_ff;
      produce   = 1'b0;
      if (take_byte) begin
         unique case (pos_ff)
            POS_HEADER: begin
               // A header without its sync bit is dropped to regain packet alignment.
               if (req_packet_byte[SYNC_BIT]) begin
                  header_in = req_packet_byte;
                  pos_in    = POS_X_MOVE;
               end
            end
            POS_X_MOVE: begin
               xmove_in = req_packet_byte;
               pos_in   = POS_Y_MOVE;
            end
            default: begin
               ptr_x_in = new_x;
               ptr_y_in = new_y;
               pos_in   = POS_HEADER;
               produce  = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (stalled) begin
         if (produce) begin
            skid_valid_in = 1'b1;
            skid_in       = result;
         end
      end else if (skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end else begin
         out_valid_in = produce;
         if (produce) begin
            out_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= WIDTH_RESET;
         height_ff     <= HEIGHT_RESET;
         pos_ff        <= POS_HEADER;
         ptr_x_ff      <= X_RESET;
         ptr_y_ff      <= Y_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         pos_ff        <= pos_in;
         ptr_x_ff      <= ptr_x_in;
         ptr_y_ff      <= ptr_y_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      header_ff <= header_in;
      xmove_ff  <= xmove_in;
      out_ff    <= out_in;
      skid_ff   <= skid_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_pixel_x = out_ff.pixel_x;
   assign rsp_pixel_y = out_ff.pixel_y;
   assign rsp_cell_x  = out_ff.cell_x;
   assign rsp_cell_y  = out_ff.cell_y;
   assign rsp_buttons = out_ff.buttons;

`ifndef SYNTHESIS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a response while the output register is empty");

   a_packet_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      produce |=> rsp_valid)
      else $error("completed packet produced no response");

   a_header_synced: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != POS_HEADER) |-> header_ff[SYNC_BIT])
      else $error("packet in progress with a header lacking its sync bit");

   a_ignored_byte_holds: assert property (@(posedge clock) disable iff (reset)
      !take_byte |=> $stable(pos_ff) && $stable(ptr_x_ff) && $stable(ptr_y_ff))
      else $error("packet state moved without an accepted mouse byte");
`endif

endmodule
